>>> rtl/core/bsv_pkg.sv
package bsv_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_source;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         event_res;
        logic signed [63:0] value;
        logic [5:0]         depth;
        logic [3:0]         error_code;
        logic               doc_done;
    } out_item_t;

    // byte as seen by the parser, with its class decoded up front
    typedef struct packed {
        logic [7:0] data_byte;
        logic       eos;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_minus;
        logic       is_plus;
        logic       is_colon;
        logic       is_e;
        logic       is_i;
        logic       is_l;
        logic       is_d;
    } cls_t;

    localparam logic [3:0] EV_PENDING = 4'd0;
    localparam logic [3:0] EV_LIST    = 4'd1;
    localparam logic [3:0] EV_DICT    = 4'd2;
    localparam logic [3:0] EV_CLOSE   = 4'd3;
    localparam logic [3:0] EV_INT     = 4'd4;
    localparam logic [3:0] EV_SBYTE   = 4'd5;
    localparam logic [3:0] EV_SEND    = 4'd6;
    localparam logic [3:0] EV_KBYTE   = 4'd7;
    localparam logic [3:0] EV_KEND    = 4'd8;
    localparam logic [3:0] EV_NONE    = 4'd9;
    localparam logic [3:0] EV_ERROR   = 4'd10;
    localparam logic [3:0] EV_IGNORED = 4'd11;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_EARLY_END = 4'd1;
    localparam logic [3:0] ERR_BAD_TYPE  = 4'd2;
    localparam logic [3:0] ERR_EMPTY     = 4'd3;
    localparam logic [3:0] ERR_NEG_ZERO  = 4'd4;
    localparam logic [3:0] ERR_TOO_LONG  = 4'd5;
    localparam logic [3:0] ERR_OVERFLOW  = 4'd6;
    localparam logic [3:0] ERR_NEG_LEN   = 4'd7;
    localparam logic [3:0] ERR_NO_COLON  = 4'd8;
    localparam logic [3:0] ERR_STR_LONG  = 4'd9;
    localparam logic [3:0] ERR_NO_TERM   = 4'd10;
    localparam logic [3:0] ERR_TOO_DEEP  = 4'd11;
    localparam logic [3:0] ERR_KEY_ORDER = 4'd12;
    localparam logic [3:0] ERR_DUP_KEY   = 4'd13;
    localparam logic [3:0] ERR_KEY_STORE = 4'd14;

    localparam logic REG_MAX_DEPTH      = 1'b0;
    localparam logic REG_MAX_STRING_LEN = 1'b1;

endpackage

>>> rtl/core/bencode_stream_validator_core.sv
// channel   | handshake                    | beat
// ----------+------------------------------+-------------------------------
// item      | push / full                  | data_byte, end_of_source
// result    | empty / pop                  | event, value, depth, error, done
// cfg       | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// One byte per cycle sustained while neither queue stalls; a byte goes from push through
// the input queue, then the parser step and result queue write, to the result queue head.
// The parser step does one key store read and one write per cycle; reads are
// issued from the next parser state, so the read data is ready for the step that uses it.
// Reset clears control state; top frame, frame and key stores are not cleared.
// Both 2-entry queues stall independently; a full result queue holds the parser.
module bencode_stream_validator_core #(
    parameter int MAX_DEPTH     = 32,
    parameter int MAX_KEY_BYTES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  bsv_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output bsv_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);
    import bsv_pkg::*;

    logic [5:0]  max_depth_reg;
    logic [31:0] max_str_len_reg;
    logic        avail, take, res_full, res_push;
    cls_t        head;
    out_item_t   res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg   <= 6'd32;
            max_str_len_reg <= 32'hFFFF_FFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAX_DEPTH:      max_depth_reg <= cfg_data[5:0];
                REG_MAX_STRING_LEN: max_str_len_reg <= cfg_data;
                default:            max_depth_reg <= max_depth_reg;
            endcase
        end
    end

    bsv_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .take  (take),
        .avail (avail),
        .head  (head)
    );

    bsv_parse #(
        .MAX_DEPTH     (MAX_DEPTH),
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .avail       (avail),
        .head        (head),
        .take        (take),
        .max_depth   (max_depth_reg),
        .max_str_len (max_str_len_reg),
        .res_full    (res_full),
        .res_push    (res_push),
        .res         (res)
    );

    bsv_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (res_push),
        .full  (res_full),
        .wdata (res),
        .pop   (pop),
        .empty (empty),
        .rdata (result)
    );

endmodule

>>> rtl/core/bsv_ram.sv
module bsv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/bsv_front.sv
module bsv_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  bsv_pkg::in_item_t item,
    input  logic              take,
    output logic              avail,
    output bsv_pkg::cls_t     head
);
    import bsv_pkg::*;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;

    cls_t       slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cls_t       cls;
    logic       wr, rd;
    logic [7:0] diff;

    always_comb
    begin
        diff         = item.data_byte - CH_ZERO;
        cls.data_byte = item.data_byte;
        cls.eos      = item.end_of_source;
        cls.is_digit = (item.data_byte >= CH_ZERO) && (item.data_byte <= CH_NINE);
        cls.digit    = diff[3:0];
        cls.is_minus = item.data_byte == CH_MINUS;
        cls.is_plus  = item.data_byte == CH_PLUS;
        cls.is_colon = item.data_byte == CH_COLON;
        cls.is_e     = item.data_byte == CH_E;
        cls.is_i     = item.data_byte == CH_I;
        cls.is_l     = item.data_byte == CH_L;
        cls.is_d     = item.data_byte == CH_D;
    end

    assign full  = cnt_reg == 2'd2;
    assign avail = cnt_reg != 2'd0;
    assign head  = slot_reg[rptr_reg];
    assign wr    = push && !full;
    assign rd    = take && avail;

    always_comb
    begin
        wptr_next = wr ? ~wptr_reg : wptr_reg;
        rptr_next = rd ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wptr_reg] <= cls;
        end
    end

endmodule

>>> rtl/core/bsv_outq.sv
module bsv_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    output logic               full,
    input  bsv_pkg::out_item_t wdata,
    input  logic               pop,
    output logic               empty,
    output bsv_pkg::out_item_t rdata
);
    import bsv_pkg::*;

    out_item_t  slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       wr, rd;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign rdata = slot_reg[rptr_reg];
    assign wr    = wr_en && !full;
    assign rd    = pop && !empty;

    always_comb
    begin
        wptr_next = wr ? ~wptr_reg : wptr_reg;
        rptr_next = rd ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/core/bsv_parse.sv
module bsv_parse #(
    parameter int MAX_DEPTH     = 32,
    parameter int MAX_KEY_BYTES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               avail,
    input  bsv_pkg::cls_t      head,
    output logic               take,
    input  logic [5:0]         max_depth,
    input  logic [31:0]        max_str_len,
    input  logic               res_full,
    output logic               res_push,
    output bsv_pkg::out_item_t res
);
    import bsv_pkg::*;

    localparam int OFW = $clog2(MAX_DEPTH + 1);
    localparam int FAW = $clog2(MAX_DEPTH);
    localparam int KLW = $clog2(MAX_KEY_BYTES + 1);
    localparam int KAW = $clog2(MAX_DEPTH * MAX_KEY_BYTES);
    localparam int FW  = KLW + 3;
    localparam logic [4:0] NUM_CHARS_MAX = 5'd20;

    typedef enum logic [5:0] {
        PH_ROOT = 6'b000001,
        PH_ITEM = 6'b000010,
        PH_INT  = 6'b000100,
        PH_LEN  = 6'b001000,
        PH_BODY = 6'b010000,
        PH_DONE = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        CMP_EQ = 2'd0,
        CMP_GT = 2'd1,
        CMP_LT = 2'd2
    } cmp_t;

    logic [OFW-1:0] of_reg, of_next;
    phase_t         phase_reg, phase_next;
    logic [63:0]    acc_reg, acc_next;
    logic [4:0]     nch_reg, nch_next;
    logic           neg_reg, neg_next;
    logic [31:0]    left_reg, left_next;
    cmp_t           cmp_reg, cmp_next;
    logic [KLW-1:0] kp_reg, kp_next;
    logic           err_reg, err_next;
    logic           tdict_reg, tdict_next;
    logic           tawait_reg, tawait_next;
    logic           thas_reg, thas_next;
    logic [KLW-1:0] tklen_reg, tklen_next;
    logic           fwd_vld_reg, fwd_vld_next;
    logic [FW-1:0]  fwd_data_reg;

    // frames below the top one live in u_frame_ram; the top frame sits in registers
    logic           fw_we;
    logic [FAW-1:0] fw_addr, fr_raddr;
    logic [FW-1:0]  fw_data, fr_rdata, below;
    logic           kw_we;
    logic [KAW-1:0] kw_addr, kr_addr;
    logic [7:0]     kr_data;

    logic           go, st, in_key;
    logic [5:0]     lim;
    logic [63:0]    n_acc, na_acc, nb_lim;
    logic [4:0]     n_ch, na_ch, digits;
    logic           n_neg, na_neg;
    logic [67:0]    prod;
    logic           nb_take, nb_err;
    logic [3:0]     nb_code;

    logic           do_len, do_int, do_body, do_close, do_push, do_send, do_vdone;
    logic           f;
    logic [3:0]     f_code;
    logic [7:0]     send_last;
    cmp_t           c2;
    logic [3:0]     ev, ec;
    logic [63:0]    val;
    logic           dn;
    logic [31:0]    t32, fr32, kr32, kw32;

    assign go       = avail && !res_full;
    assign take     = go;
    assign res_push = go;
    assign st       = (phase_reg == PH_ROOT) || (phase_reg == PH_ITEM);
    assign in_key   = (of_reg != '0) && tdict_reg && !tawait_reg;
    assign lim      = (32'(max_depth) < MAX_DEPTH) ? max_depth : 6'(MAX_DEPTH);
    assign below    = fwd_vld_reg ? fwd_data_reg : fr_rdata;

    // number lexer shared by integers and length prefixes
    always_comb
    begin
        n_acc   = st ? 64'd0 : acc_reg;
        n_ch    = st ? 5'd0 : nch_reg;
        n_neg   = st ? 1'b0 : neg_reg;
        nb_lim  = {1'b0, {63{1'b1}}} + {63'd0, n_neg};
        digits  = n_ch - {4'd0, n_neg};
        prod    = ({4'd0, n_acc} << 3) + ({4'd0, n_acc} << 1) + {64'd0, head.digit};
        na_acc  = n_acc;
        na_ch   = n_ch;
        na_neg  = n_neg;
        nb_take = 1'b0;
        nb_err  = 1'b0;
        nb_code = ERR_NONE;
        if (head.is_minus && n_ch == 5'd0)
        begin
            na_neg  = 1'b1;
            na_ch   = 5'd1;
            nb_take = 1'b1;
        end
        else if (head.is_digit)
        begin
            if (n_ch >= NUM_CHARS_MAX)
            begin
                nb_err  = 1'b1;
                nb_code = ERR_TOO_LONG;
            end
            else if (digits == 5'd1 && n_acc == 64'd0)
            begin
                nb_err  = 1'b1;
                nb_code = ERR_EMPTY;
            end
            else
            begin
                // saturate one above the limit; reported when the number ends
                na_acc  = (prod > {4'd0, nb_lim}) ? nb_lim + 64'd1 : prod[63:0];
                na_ch   = n_ch + 5'd1;
                nb_take = 1'b1;
            end
        end
        else if (digits == 5'd0)
        begin
            nb_err  = 1'b1;
            nb_code = ERR_EMPTY;
        end
        else if (n_neg && n_acc == 64'd0)
        begin
            nb_err  = 1'b1;
            nb_code = ERR_NEG_ZERO;
        end
        else if (n_acc > nb_lim)
        begin
            nb_err  = 1'b1;
            nb_code = ERR_OVERFLOW;
        end
    end

    always_comb
    begin
        of_next     = of_reg;
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        nch_next    = nch_reg;
        neg_next    = neg_reg;
        left_next   = left_reg;
        cmp_next    = cmp_reg;
        kp_next     = kp_reg;
        err_next    = err_reg;
        tdict_next  = tdict_reg;
        tawait_next = tawait_reg;
        thas_next   = thas_reg;
        tklen_next  = tklen_reg;
        ev          = EV_PENDING;
        ec          = ERR_NONE;
        val         = 64'd0;
        dn          = 1'b0;
        do_len      = 1'b0;
        do_int      = 1'b0;
        do_body     = 1'b0;
        do_close    = 1'b0;
        do_push     = 1'b0;
        do_send     = 1'b0;
        do_vdone    = 1'b0;
        f           = 1'b0;
        f_code      = ERR_NONE;
        send_last   = 8'd0;
        c2          = cmp_reg;
        fw_we       = 1'b0;
        kw_we       = 1'b0;
        t32         = 32'(of_reg) - 32'd1;
        fw_addr     = t32[FAW-1:0];
        fw_data     = {tdict_reg, tawait_reg, thas_reg, tklen_reg};
        kw32        = t32 * 32'(MAX_KEY_BYTES) + 32'(kp_reg);
        kw_addr     = kw32[KAW-1:0];

        if (go)
        begin
            if (err_reg)
            begin
                ev = EV_IGNORED;
            end
            else
            begin
                case (phase_reg)
                    PH_ROOT, PH_ITEM:
                    begin
                        if (in_key)
                        begin
                            if (head.is_e)
                            begin
                                do_close = 1'b1;
                            end
                            else
                            begin
                                do_len = 1'b1;
                            end
                        end
                        else if (of_reg == '0 && lim <= 6'd1)
                        begin
                            f      = 1'b1;
                            f_code = ERR_TOO_DEEP;
                        end
                        else if (head.is_d || head.is_l)
                        begin
                            do_push = 1'b1;
                        end
                        else if (head.is_i)
                        begin
                            acc_next   = 64'd0;
                            nch_next   = 5'd0;
                            neg_next   = 1'b0;
                            phase_next = PH_INT;
                        end
                        else if (head.is_digit || head.is_minus || head.is_plus)
                        begin
                            do_len = 1'b1;
                        end
                        else if (head.is_e && of_reg != '0 && !tdict_reg)
                        begin
                            do_close = 1'b1;
                        end
                        else
                        begin
                            f      = 1'b1;
                            f_code = ERR_BAD_TYPE;
                        end
                    end
                    PH_INT:  do_int = 1'b1;
                    PH_LEN:  do_len = 1'b1;
                    PH_BODY: do_body = 1'b1;
                    default: ev = EV_NONE;
                endcase
            end

            if (do_push)
            begin
                if (32'(of_reg) + 32'd1 >= 32'(lim))
                begin
                    f      = 1'b1;
                    f_code = ERR_TOO_DEEP;
                end
                else
                begin
                    fw_we       = of_reg != '0;
                    tdict_next  = head.is_d;
                    tawait_next = 1'b0;
                    thas_next   = 1'b0;
                    tklen_next  = '0;
                    of_next     = of_reg + OFW'(1);
                    ev          = head.is_d ? EV_DICT : EV_LIST;
                    phase_next  = PH_ITEM;
                end
            end

            if (do_close)
            begin
                of_next     = of_reg - OFW'(1);
                ev          = EV_CLOSE;
                tdict_next  = below[FW-1];
                tawait_next = below[FW-2];
                thas_next   = below[FW-3];
                tklen_next  = below[KLW-1:0];
                do_vdone    = 1'b1;
            end

            if (do_int)
            begin
                acc_next = na_acc;
                nch_next = na_ch;
                neg_next = na_neg;
                if (nb_err)
                begin
                    f      = 1'b1;
                    f_code = nb_code;
                end
                else if (!nb_take)
                begin
                    if (!head.is_e)
                    begin
                        f      = 1'b1;
                        f_code = ERR_NO_TERM;
                    end
                    else
                    begin
                        ev       = EV_INT;
                        val      = n_neg ? 64'd0 - n_acc : n_acc;
                        do_vdone = 1'b1;
                    end
                end
            end

            if (do_len)
            begin
                acc_next   = na_acc;
                nch_next   = na_ch;
                neg_next   = na_neg;
                phase_next = PH_LEN;
                if (st && in_key)
                begin
                    cmp_next = CMP_EQ;
                    kp_next  = '0;
                end
                if (nb_err)
                begin
                    f      = 1'b1;
                    f_code = nb_code;
                end
                else if (!nb_take)
                begin
                    if (n_neg)
                    begin
                        f      = 1'b1;
                        f_code = ERR_NEG_LEN;
                    end
                    else if (!head.is_colon)
                    begin
                        f      = 1'b1;
                        f_code = ERR_NO_COLON;
                    end
                    else if (n_acc > {32'd0, max_str_len})
                    begin
                        f      = 1'b1;
                        f_code = ERR_STR_LONG;
                    end
                    else if (in_key && n_acc > 64'(MAX_KEY_BYTES))
                    begin
                        f      = 1'b1;
                        f_code = ERR_KEY_STORE;
                    end
                    else if (n_acc == 64'd0)
                    begin
                        do_send   = 1'b1;
                        send_last = 8'd0;
                    end
                    else
                    begin
                        left_next  = n_acc[31:0];
                        phase_next = PH_BODY;
                        val        = n_acc;
                    end
                end
            end

            if (do_body)
            begin
                if (in_key)
                begin
                    if (cmp_reg == CMP_EQ)
                    begin
                        if (kp_reg >= tklen_reg || 32'(kp_reg) >= MAX_KEY_BYTES)
                        begin
                            cmp_next = CMP_GT;
                        end
                        else if (head.data_byte > kr_data)
                        begin
                            cmp_next = CMP_GT;
                        end
                        else if (head.data_byte < kr_data)
                        begin
                            cmp_next = CMP_LT;
                        end
                    end
                    kw_we   = 32'(kp_reg) < MAX_KEY_BYTES;
                    kp_next = kp_reg + KLW'(1);
                    ev      = EV_KBYTE;
                end
                else
                begin
                    ev = EV_SBYTE;
                end
                val       = {56'd0, head.data_byte};
                left_next = left_reg - 32'd1;
                if (left_reg == 32'd1)
                begin
                    do_send   = 1'b1;
                    send_last = head.data_byte;
                end
            end

            if (do_send)
            begin
                if (in_key)
                begin
                    c2 = (cmp_next == CMP_EQ && kp_next < tklen_reg) ? CMP_LT : cmp_next;
                    if (c2 == CMP_LT)
                    begin
                        f      = 1'b1;
                        f_code = ERR_KEY_ORDER;
                    end
                    else if (c2 == CMP_EQ && thas_reg)
                    begin
                        f      = 1'b1;
                        f_code = ERR_DUP_KEY;
                    end
                    else
                    begin
                        ev          = EV_KEND;
                        val         = {56'd0, send_last};
                        tklen_next  = kp_next;
                        thas_next   = 1'b1;
                        tawait_next = 1'b1;
                        phase_next  = PH_ITEM;
                    end
                end
                else
                begin
                    ev       = EV_SEND;
                    val      = {56'd0, send_last};
                    do_vdone = 1'b1;
                end
            end

            if (do_vdone)
            begin
                if (of_next == '0)
                begin
                    phase_next = PH_DONE;
                    dn         = 1'b1;
                end
                else
                begin
                    tawait_next = 1'b0;
                    phase_next  = PH_ITEM;
                end
            end

            if (f)
            begin
                ev       = EV_ERROR;
                ec       = f_code;
                val      = 64'd0;
                err_next = 1'b1;
            end

            if (head.eos && !err_reg && !f && phase_next != PH_DONE)
            begin
                ev       = EV_ERROR;
                ec       = ERR_EARLY_END;
                val      = 64'd0;
                dn       = 1'b0;
                err_next = 1'b1;
            end
        end

        res.event_res  = ev;
        res.value      = val;
        res.depth      = 6'(of_next);
        res.error_code = ec;
        res.doc_done   = dn;

        // last beat of a source rearms the parser
        if (go && head.eos)
        begin
            of_next    = '0;
            phase_next = PH_ROOT;
            acc_next   = 64'd0;
            nch_next   = 5'd0;
            neg_next   = 1'b0;
            left_next  = 32'd0;
            cmp_next   = CMP_EQ;
            kp_next    = '0;
            err_next   = 1'b0;
        end

        fr32         = 32'(of_next) - 32'd2;
        fr_raddr     = fr32[FAW-1:0];
        kr32         = (32'(of_next) - 32'd1) * 32'(MAX_KEY_BYTES) + 32'(kp_next);
        kr_addr      = kr32[KAW-1:0];
        fwd_vld_next = fw_we && (fw_addr == fr_raddr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            of_reg      <= '0;
            phase_reg   <= PH_ROOT;
            acc_reg     <= 64'd0;
            nch_reg     <= 5'd0;
            neg_reg     <= 1'b0;
            left_reg    <= 32'd0;
            cmp_reg     <= CMP_EQ;
            kp_reg      <= '0;
            err_reg     <= 1'b0;
            fwd_vld_reg <= 1'b0;
        end
        else
        begin
            of_reg      <= of_next;
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            nch_reg     <= nch_next;
            neg_reg     <= neg_next;
            left_reg    <= left_next;
            cmp_reg     <= cmp_next;
            kp_reg      <= kp_next;
            err_reg     <= err_next;
            fwd_vld_reg <= fwd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tdict_reg    <= tdict_next;
        tawait_reg   <= tawait_next;
        thas_reg     <= thas_next;
        tklen_reg    <= tklen_next;
        fwd_data_reg <= fw_data;
    end

    bsv_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (fw_we),
        .waddr (fw_addr),
        .wdata (fw_data),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    bsv_ram #(
        .WIDTH (8),
        .DEPTH (MAX_DEPTH * MAX_KEY_BYTES)
    ) u_key_ram (
        .clk   (clk),
        .we    (kw_we),
        .waddr (kw_addr),
        .wdata (head.data_byte),
        .raddr (kr_addr),
        .rdata (kr_data)
    );

endmodule

>>> tb/tb_top.sv
module tb_top;
    import bsv_pkg::*;

    localparam int DEPTH_CAP = 32;
    localparam int KEY_CAP   = 64;
    localparam int NUM_CAP   = 20;

    localparam int PH_ROOT = 0;
    localparam int PH_ITEM = 1;
    localparam int PH_INT  = 2;
    localparam int PH_LEN  = 3;
    localparam int PH_BODY = 4;
    localparam int PH_DONE = 5;

    localparam int KEY_EQ = 0;
    localparam int KEY_GT = 1;
    localparam int KEY_LT = 2;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    in_item_t    item;
    logic        empty;
    logic        pop;
    out_item_t   result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    bencode_stream_validator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // parser mirror
    bit               fr_dict[DEPTH_CAP];
    bit               fr_await[DEPTH_CAP];
    bit               fr_haskey[DEPTH_CAP];
    byte unsigned     key_mem[DEPTH_CAP*KEY_CAP];
    int unsigned      key_len[DEPTH_CAP];
    int unsigned      n_open;
    int               phase;
    longint unsigned  acc;
    int unsigned      nchars;
    bit               neg;
    int unsigned      str_left;
    int               key_cmp;
    int unsigned      key_pos;
    bit               latched;
    int unsigned      lim_depth;
    longint unsigned  lim_str;

    logic [3:0]       o_ev;
    longint unsigned  o_val;
    logic [3:0]       o_err;
    bit               o_done;

    function automatic int unsigned top_ix();
        return (n_open - 1) % DEPTH_CAP;
    endfunction

    function automatic int unsigned depth_lim();
        return (lim_depth < DEPTH_CAP) ? lim_depth : DEPTH_CAP;
    endfunction

    function automatic void raise_err(logic [3:0] code);
        o_ev = EV_ERROR;
        o_err = code;
        o_val = 0;
        latched = 1;
    endfunction

    function automatic bit in_key();
        if (n_open == 0)
            return 0;
        return fr_dict[top_ix()] && !fr_await[top_ix()];
    endfunction

    function automatic void value_done();
        if (n_open == 0)
        begin
            phase = PH_DONE;
            o_done = 1;
        end
        else
        begin
            fr_await[top_ix()] = 0;
            phase = PH_ITEM;
        end
    endfunction

    function automatic void open_frame(bit dict);
        int unsigned n;
        if (n_open + 1 >= depth_lim())
        begin
            raise_err(ERR_TOO_DEEP);
            return;
        end
        n = n_open % DEPTH_CAP;
        fr_dict[n] = dict;
        fr_await[n] = 0;
        fr_haskey[n] = 0;
        key_len[n] = 0;
        n_open++;
        o_ev = dict ? EV_DICT : EV_LIST;
        phase = PH_ITEM;
    endfunction

    function automatic void close_frame();
        n_open--;
        o_ev = EV_CLOSE;
        value_done();
    endfunction

    function automatic void start_number(int ph);
        acc = 0;
        nchars = 0;
        neg = 0;
        phase = ph;
        if (ph == PH_LEN && in_key())
        begin
            key_cmp = KEY_EQ;
            key_pos = 0;
        end
    endfunction

    // 1: character taken, 0: number ended cleanly, -1: error raised
    function automatic int number_char(byte unsigned b);
        longint unsigned lim;
        longint unsigned d;
        int unsigned digits;
        lim = 64'h7FFF_FFFF_FFFF_FFFF + (neg ? 1 : 0);
        digits = nchars - (neg ? 1 : 0);
        if (b == "-" && nchars == 0)
        begin
            neg = 1;
            nchars = 1;
            return 1;
        end
        if (b >= "0" && b <= "9")
        begin
            d = b - "0";
            if (nchars >= NUM_CAP)
            begin
                raise_err(ERR_TOO_LONG);
                return -1;
            end
            if (digits == 1 && acc == 0)
            begin
                raise_err(ERR_EMPTY);
                return -1;
            end
            if (acc > (lim - d) / 10)
                acc = lim + 1;
            else
                acc = acc * 10 + d;
            nchars++;
            return 1;
        end
        if (digits == 0)
        begin
            raise_err(ERR_EMPTY);
            return -1;
        end
        if (neg && acc == 0)
        begin
            raise_err(ERR_NEG_ZERO);
            return -1;
        end
        if (acc > lim)
        begin
            raise_err(ERR_OVERFLOW);
            return -1;
        end
        return 0;
    endfunction

    function automatic void finish_key(byte unsigned last);
        int unsigned t;
        t = top_ix();
        if (key_cmp == KEY_EQ && key_pos < key_len[t])
            key_cmp = KEY_LT;
        if (key_cmp == KEY_LT)
        begin
            raise_err(ERR_KEY_ORDER);
            return;
        end
        if (key_cmp == KEY_EQ && fr_haskey[t])
        begin
            raise_err(ERR_DUP_KEY);
            return;
        end
        o_ev = EV_KEND;
        o_val = last;
        key_len[t] = key_pos;
        fr_haskey[t] = 1;
        fr_await[t] = 1;
        phase = PH_ITEM;
    endfunction

    function automatic void finish_string(byte unsigned last);
        if (in_key())
        begin
            finish_key(last);
            return;
        end
        o_ev = EV_SEND;
        o_val = last;
        value_done();
    endfunction

    function automatic void length_char(byte unsigned b);
        if (number_char(b) != 0)
            return;
        if (neg)
            raise_err(ERR_NEG_LEN);
        else if (b != ":")
            raise_err(ERR_NO_COLON);
        else if (acc > lim_str)
            raise_err(ERR_STR_LONG);
        else if (in_key() && acc > KEY_CAP)
            raise_err(ERR_KEY_STORE);
        else if (acc == 0)
            finish_string(0);
        else
        begin
            str_left = acc;
            phase = PH_BODY;
            o_val = acc;
        end
    endfunction

    function automatic void integer_char(byte unsigned b);
        if (number_char(b) != 0)
            return;
        if (b != "e")
        begin
            raise_err(ERR_NO_TERM);
            return;
        end
        o_ev = EV_INT;
        o_val = neg ? 64'd0 - acc : acc;
        value_done();
    endfunction

    function automatic void body_char(byte unsigned b);
        int unsigned t;
        byte unsigned s;
        if (in_key())
        begin
            t = top_ix();
            if (key_cmp == KEY_EQ)
            begin
                if (key_pos >= key_len[t] || key_pos >= KEY_CAP)
                    key_cmp = KEY_GT;
                else
                begin
                    s = key_mem[t*KEY_CAP + key_pos];
                    if (b > s)
                        key_cmp = KEY_GT;
                    else if (b < s)
                        key_cmp = KEY_LT;
                end
            end
            if (key_pos < KEY_CAP)
                key_mem[t*KEY_CAP + key_pos] = b;
            key_pos++;
            o_ev = EV_KBYTE;
        end
        else
            o_ev = EV_SBYTE;
        o_val = b;
        str_left--;
        if (str_left == 0)
            finish_string(b);
    endfunction

    function automatic void item_char(byte unsigned b);
        bit root;
        bit is_list;
        root = (n_open == 0);
        is_list = !root && !fr_dict[top_ix()];
        if (in_key())
        begin
            if (b == "e")
                close_frame();
            else
            begin
                start_number(PH_LEN);
                length_char(b);
            end
            return;
        end
        if (root && depth_lim() <= 1)
            raise_err(ERR_TOO_DEEP);
        else if (b == "d")
            open_frame(1);
        else if (b == "l")
            open_frame(0);
        else if (b == "i")
            start_number(PH_INT);
        else if ((b >= "0" && b <= "9") || b == "-" || b == "+")
        begin
            start_number(PH_LEN);
            length_char(b);
        end
        else if (b == "e" && is_list)
            close_frame();
        else
            raise_err(ERR_BAD_TYPE);
    endfunction

    function automatic void rearm_parser();
        n_open = 0;
        phase = PH_ROOT;
        acc = 0;
        nchars = 0;
        neg = 0;
        str_left = 0;
        key_cmp = KEY_EQ;
        key_pos = 0;
        latched = 0;
    endfunction

    function automatic out_item_t parse_byte(in_item_t it);
        out_item_t r;
        bit was_latched;
        was_latched = latched;
        o_ev = EV_PENDING;
        o_val = 0;
        o_err = ERR_NONE;
        o_done = 0;
        if (latched)
            o_ev = EV_IGNORED;
        else
            case (phase)
                PH_ROOT, PH_ITEM: item_char(it.data_byte);
                PH_INT:           integer_char(it.data_byte);
                PH_LEN:           length_char(it.data_byte);
                PH_BODY:          body_char(it.data_byte);
                default:          o_ev = EV_NONE;
            endcase
        if (it.end_of_source && !was_latched && !latched && phase != PH_DONE)
            raise_err(ERR_EARLY_END);
        r.event_res = o_ev;
        r.value = o_val;
        r.depth = n_open[5:0];
        r.error_code = o_err;
        r.doc_done = o_done;
        if (it.end_of_source)
            rearm_parser();
        return r;
    endfunction

    // traffic
    in_item_t   byte_q[$];
    out_item_t  event_q[$];
    int         send_idle;
    int         recv_idle;
    int         recv_hold;
    bit         hold_req;
    bit         beat_in;
    int         n_bad;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (beat_in)
                void'(byte_q.pop_front());
            if (byte_q.size() > (beat_in ? 1 : 0) - (beat_in ? 1 : 0)
                && byte_q.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                push <= 1'b1;
                item <= byte_q[0];
            end
            else
                push <= 1'b0;
        end
    end

    // receiver, with its own count of held-off cycles
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req)
            begin
                recv_hold = 300;
                hold_req = 0;
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            beat_in <= push && !full;
            if (push && !full)
                event_q.push_back(parse_byte(item));
            if (pop && !empty)
            begin
                if (event_q.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected result beat %p", result);
                end
                else
                begin
                    want = event_q.pop_front();
                    if (result.event_res !== want.event_res || result.value !== want.value
                        || result.depth !== want.depth || result.error_code !== want.error_code
                        || result.doc_done !== want.doc_done)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("mismatch: expected %p actual %p", want, result);
                    end
                end
            end
        end
    end

    // document builder
    byte unsigned doc_buf[$];
    int           rand_bytes;

    task automatic put_s(string s);
        foreach (s[i])
            doc_buf.push_back(s[i]);
    endtask

    task automatic commit_doc();
        in_item_t it;
        foreach (doc_buf[i])
        begin
            it.data_byte = doc_buf[i];
            it.end_of_source = (i == doc_buf.size() - 1);
            byte_q.push_back(it);
        end
        rand_bytes += doc_buf.size();
        doc_buf.delete();
    endtask

    task automatic doc(string s);
        put_s(s);
        commit_doc();
    endtask

    task automatic put_int();
        longint v;
        case ($urandom_range(7))
            0: v = 64'h8000_0000_0000_0000;
            1: v = 64'h7FFF_FFFF_FFFF_FFFF;
            2: v = {$urandom, $urandom};
            3: v = 0;
            default: v = longint'($urandom_range(2000)) - 1000;
        endcase
        put_s($sformatf("i%0de", v));
    endtask

    task automatic put_bytes(int n, int lo, int hi);
        repeat (n)
            doc_buf.push_back($urandom_range(hi, lo));
    endtask

    task automatic gen_value(int lvl);
        int n;
        int base;
        int klen;
        case (lvl > 0 ? $urandom_range(5) : $urandom_range(1))
            0: put_int();
            1:
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(5);
                put_s($sformatf("%0d:", n));
                put_bytes(n, 0, 255);
            end
            2, 3:
            begin
                put_s("l");
                repeat ($urandom_range(3))
                    gen_value(lvl - 1);
                put_s("e");
            end
            default:
            begin
                put_s("d");
                n = $urandom_range(3);
                base = $urandom_range(40, 33);
                for (int k = 0; k < n; k++)
                begin
                    klen = $urandom_range(3);
                    put_s($sformatf("%0d:", klen + 1));
                    case ($urandom_range(19))
                        0: doc_buf.push_back(base);         // repeats previous lead byte
                        1: doc_buf.push_back(base - 1);     // out of order
                        default:
                        begin
                            base = base + $urandom_range(12, 1);
                            doc_buf.push_back(base);
                        end
                    endcase
                    put_bytes(klen, 0, 255);
                    gen_value(lvl - 1);
                end
                put_s("e");
            end
        endcase
    endtask

    task automatic random_docs(int nbytes);
        int stop_at;
        int p;
        stop_at = rand_bytes + nbytes;
        while (rand_bytes < stop_at)
        begin
            if ($urandom_range(9) == 0)
                put_bytes($urandom_range(6, 1), 0, 255);
            else
            begin
                gen_value($urandom_range(4));
                case ($urandom_range(15))
                    0, 1:
                    begin
                        p = $urandom_range(doc_buf.size() - 1);
                        doc_buf[p] = $urandom_range(255);
                    end
                    2: doc_buf = doc_buf[0:$urandom_range(doc_buf.size() - 1)];
                    3: put_bytes($urandom_range(3, 1), 0, 255);
                    default: ;
                endcase
            end
            commit_doc();
        end
    endtask

    task automatic drain();
        while (byte_q.size() != 0 || push || event_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_MAX_DEPTH)
            lim_depth = data[5:0];
        else
            lim_str = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MAX_DEPTH;
        cfg_data = '0;
        beat_in = 0;
        hold_req = 0;
        recv_hold = 0;
        n_bad = 0;
        rand_bytes = 0;
        lim_depth = 32;
        lim_str = 64'hFFFF_FFFF;
        rearm_parser();
        send_idle = 38;
        recv_idle = 72;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        doc("i-9223372036854775808e");
        doc("i9223372036854775807e");
        doc("i9223372036854775808e");
        doc("i-9223372036854775809e");
        doc("i-0e");
        doc("i03e");
        doc("i-03e");
        doc("i-e");
        doc("ie");
        doc("i123456789012345678901e");
        doc("i12x");
        doc("+");
        doc("3x");
        doc("-1:");
        doc("le");
        doc("de");
        doc("d1:b0:1:a0:e");
        doc("d1:a0:1:a0:e");
        doc("d2:ab0:1:a0:e");
        doc("d0:i1e1:ai2e1:b0:e");
        doc("dxe");
        doc("d1:ae");
        doc("e");
        doc("x");
        doc("i1ex");
        doc("l");
        doc("4:spam");
        put_s("d65:");
        put_bytes(65, 97, 122);
        put_s("i0ee");
        commit_doc();
        drain();

        write_reg(REG_MAX_DEPTH, 2);
        write_reg(REG_MAX_STRING_LEN, 5);
        doc("ll");
        doc("6:abcdef");
        doc("5:abcde");
        random_docs(200);
        drain();

        send_idle = 72;
        recv_idle = 38;
        write_reg(REG_MAX_DEPTH, 63);
        write_reg(REG_MAX_STRING_LEN, 32'hFFFF_FFFF);
        hold_req = 1;
        put_s("4294967295:");
        commit_doc();
        repeat (34) put_s("l");
        repeat (34) put_s("e");
        commit_doc();
        random_docs(200);
        drain();

        write_reg(REG_MAX_DEPTH, 1);
        write_reg(REG_MAX_STRING_LEN, 0);
        doc("i1e");
        doc("0:");
        random_docs(40);
        drain();
        write_reg(REG_MAX_DEPTH, 0);
        random_docs(30);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_reg(REG_MAX_DEPTH, 32);
        write_reg(REG_MAX_STRING_LEN, 40);
        hold_req = 1;
        random_docs(250);
        drain();

        if (n_bad == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
